/* rtl/core/ple_pkg.sv */
package ple_pkg;

  localparam int DEF_POOL_DEPTH = 16;
  // Listing stops after this many values
  localparam int MAX_RESULTS    = 16;

  localparam int OP_W     = 3;
  localparam int POS_W    = 5;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int HELD_W   = 5;

  typedef enum logic [OP_W-1:0] {
    OP_LIST      = 3'd0,
    OP_INS_FRONT = 3'd1,
    OP_INS_BACK  = 3'd2,
    OP_INS_AT    = 3'd3,
    OP_DEL_FRONT = 3'd4,
    OP_DEL_BACK  = 3'd5,
    OP_DEL_AT    = 3'd6,
    OP_NOP       = 3'd7
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_INVAL = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_WALK,
    S_LIST,
    S_INS_LINK,
    S_INS_FIX,
    S_DEL_FIX,
    S_REPLY
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic    load;        // capture input item
    logic    seek;        // cursor to head, load step count
    logic    step;        // follow one forward link
    logic    latch;       // capture neighbors and free node
    logic    ins_link;    // write new node
    logic    ins_fix;     // patch neighbors, allocate
    logic    del_fix;     // unlink cursor node, release
    logic    set_st;
    status_e st;
    logic    emit_item;   // listing result
    logic    emit_reply;  // single result with stored status
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_e  op;
    logic is_ins;
    logic empty;
    logic full;
    logic ins_pos_ok;
    logic del_pos_ok;
    logic p_one;
    logic steps_zero;
    logic slot_free;
  } sts_t;

endpackage

/* rtl/core/ple_ram.sv */
module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/core/ple_ctrl.sv */
module ple_ctrl
  import ple_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.st   = ST_DONE;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.set_st = 1'b1;
        case (sts_i.op)
          OP_LIST: begin
            if (sts_i.empty) begin
              cmd_o.st = ST_EMPTY;
              state_d  = S_REPLY;
            end else begin
              cmd_o.seek = 1'b1;
              state_d    = S_LIST;
            end
          end
          OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
            // position is checked before the pool
            if (!sts_i.ins_pos_ok) begin
              cmd_o.st = ST_INVAL;
              state_d  = S_REPLY;
            end else if (sts_i.full) begin
              cmd_o.st = ST_FULL;
              state_d  = S_REPLY;
            end else if (sts_i.p_one) begin
              cmd_o.latch = 1'b1;
              state_d     = S_INS_LINK;
            end else begin
              cmd_o.seek = 1'b1;
              state_d    = S_WALK;
            end
          end
          OP_DEL_FRONT, OP_DEL_BACK: begin
            if (sts_i.empty) begin
              cmd_o.st = ST_EMPTY;
              state_d  = S_REPLY;
            end else begin
              cmd_o.seek = 1'b1;
              state_d    = S_WALK;
            end
          end
          OP_DEL_AT: begin
            if (!sts_i.del_pos_ok) begin
              cmd_o.st = ST_INVAL;
              state_d  = S_REPLY;
            end else begin
              cmd_o.seek = 1'b1;
              state_d    = S_WALK;
            end
          end
          default: begin
            state_d = S_REPLY;
          end
        endcase
      end
      S_WALK: begin
        if (sts_i.steps_zero) begin
          cmd_o.latch = 1'b1;
          state_d     = sts_i.is_ins ? S_INS_LINK : S_DEL_FIX;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_INS_LINK: begin
        cmd_o.ins_link = 1'b1;
        state_d        = S_INS_FIX;
      end
      S_INS_FIX: begin
        cmd_o.ins_fix = 1'b1;
        state_d       = S_REPLY;
      end
      S_DEL_FIX: begin
        cmd_o.del_fix = 1'b1;
        state_d       = S_REPLY;
      end
      S_LIST: begin
        if (sts_i.slot_free) begin
          cmd_o.emit_item = 1'b1;
          if (sts_i.steps_zero) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.step = 1'b1;
          end
        end
      end
      S_REPLY: begin
        if (sts_i.slot_free) begin
          cmd_o.emit_reply = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/ple_dp.sv */
module ple_dp
  import ple_pkg::*;
#(
  parameter int POOL_DEPTH = DEF_POOL_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmd_t                     cmd_i,
  output sts_t                     sts_o,
  input  logic [OP_W-1:0]          operation_i,
  input  logic [POS_W-1:0]         position_i,
  input  logic signed [VAL_W-1:0]  value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [STATUS_W-1:0]      status_o,
  output logic signed [VAL_W-1:0]  item_value_o,
  output logic [HELD_W-1:0]        entries_held_o,
  output logic                     last_result_o
);

  localparam int IDX_W = $clog2(POOL_DEPTH + 1);
  localparam int AW    = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CNT_W = IDX_W;
  localparam int PW    = (CNT_W + 1 > POS_W) ? CNT_W + 1 : POS_W;
  localparam logic [IDX_W-1:0] NULL_IDX = IDX_W'(POOL_DEPTH);

  // list bookkeeping
  logic [IDX_W-1:0]      head_q;
  logic [CNT_W-1:0]      count_q;
  logic [POOL_DEPTH-1:0] free_q;
  logic                  out_valid_q;

  // per-item working registers
  op_e                   op_q;
  logic [POS_W-1:0]      pos_q;
  logic [VAL_W-1:0]      val_q;
  logic [IDX_W-1:0]      cur_q, cur_d;
  logic [CNT_W-1:0]      steps_q;
  logic [IDX_W-1:0]      before_q, after_q, idx_q;
  status_e               status_q;

  logic [STATUS_W-1:0]   out_status_q;
  logic [VAL_W-1:0]      out_value_q;
  logic [HELD_W-1:0]     out_held_q;
  logic                  out_last_q;

  logic [VAL_W-1:0]      val_rdata;
  logic [IDX_W-1:0]      next_rdata, prev_rdata;

  logic                  nx_we, pv_we;
  logic [IDX_W-1:0]      nx_waddr, pv_waddr, nx_wdata, pv_wdata;

  logic [PW-1:0]         p;
  logic [PW-1:0]         cnt_ext;
  logic                  is_ins;
  logic                  list_cap;
  logic [CNT_W-1:0]      seek_len;
  logic [IDX_W-1:0]      free_idx;
  logic                  slot_free;

  // position the operation refers to
  always_comb begin
    cnt_ext = PW'(count_q);
    case (op_q)
      OP_INS_BACK:          p = cnt_ext + PW'(1);
      OP_INS_AT, OP_DEL_AT: p = PW'(pos_q);
      OP_DEL_BACK:          p = cnt_ext;
      default:              p = PW'(1);
    endcase
  end

  assign is_ins   = (op_q == OP_INS_FRONT) || (op_q == OP_INS_BACK) || (op_q == OP_INS_AT);
  assign list_cap = (32'(count_q) > 32'(MAX_RESULTS));

  // links to follow: listing counts results, insert stops on the node before,
  // delete on the node itself
  always_comb begin
    if (op_q == OP_LIST) begin
      seek_len = list_cap ? CNT_W'(MAX_RESULTS - 1) : count_q - CNT_W'(1);
    end else if (is_ins) begin
      seek_len = CNT_W'(p - PW'(2));
    end else begin
      seek_len = CNT_W'(p - PW'(1));
    end
  end

  // lowest-numbered free node
  always_comb begin
    free_idx = NULL_IDX;
    for (int i = POOL_DEPTH - 1; i >= 0; i--) begin
      if (free_q[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    sts_o.op         = op_q;
    sts_o.is_ins     = is_ins;
    sts_o.empty      = (count_q == '0);
    sts_o.full       = ~|free_q;
    sts_o.ins_pos_ok = (p != '0) && (p <= cnt_ext + PW'(1));
    sts_o.del_pos_ok = (p != '0) && (p <= cnt_ext);
    sts_o.p_one      = (p == PW'(1));
    sts_o.steps_zero = (steps_q == '0);
    sts_o.slot_free  = slot_free;
  end

  // the memories read at the cursor's next value, so their registered data
  // matches cur_q
  always_comb begin
    if (cmd_i.seek) begin
      cur_d = head_q;
    end else if (cmd_i.step) begin
      cur_d = next_rdata;
    end else begin
      cur_d = cur_q;
    end
  end

  always_comb begin
    nx_we    = 1'b0;
    nx_waddr = idx_q;
    nx_wdata = after_q;
    pv_we    = 1'b0;
    pv_waddr = idx_q;
    pv_wdata = before_q;
    if (cmd_i.ins_link) begin
      nx_we = 1'b1;
      pv_we = 1'b1;
    end else if (cmd_i.ins_fix) begin
      nx_we    = (before_q != NULL_IDX);
      nx_waddr = before_q;
      nx_wdata = idx_q;
      pv_we    = (after_q != NULL_IDX);
      pv_waddr = after_q;
      pv_wdata = idx_q;
    end else if (cmd_i.del_fix) begin
      nx_we    = (before_q != NULL_IDX);
      nx_waddr = before_q;
      nx_wdata = after_q;
      pv_we    = (after_q != NULL_IDX);
      pv_waddr = after_q;
      pv_wdata = before_q;
    end
  end

  ple_ram #(.WIDTH(VAL_W), .DEPTH(POOL_DEPTH)) u_values (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ins_link),
    .waddr_i (idx_q[AW-1:0]),
    .wdata_i (val_q),
    .raddr_i (cur_d[AW-1:0]),
    .rdata_o (val_rdata)
  );

  ple_ram #(.WIDTH(IDX_W), .DEPTH(POOL_DEPTH)) u_next (
    .clk_i   (clk_i),
    .we_i    (nx_we),
    .waddr_i (nx_waddr[AW-1:0]),
    .wdata_i (nx_wdata),
    .raddr_i (cur_d[AW-1:0]),
    .rdata_o (next_rdata)
  );

  ple_ram #(.WIDTH(IDX_W), .DEPTH(POOL_DEPTH)) u_prev (
    .clk_i   (clk_i),
    .we_i    (pv_we),
    .waddr_i (pv_waddr[AW-1:0]),
    .wdata_i (pv_wdata),
    .raddr_i (cur_d[AW-1:0]),
    .rdata_o (prev_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= NULL_IDX;
      count_q     <= '0;
      free_q      <= '1;
      out_valid_q <= 1'b0;
    end else begin
      // head moves together with the count so both agree every cycle
      if (cmd_i.ins_fix && (before_q == NULL_IDX)) begin
        head_q <= idx_q;
      end
      if (cmd_i.del_fix && (before_q == NULL_IDX)) begin
        head_q <= after_q;
      end
      if (cmd_i.ins_fix) begin
        count_q              <= count_q + CNT_W'(1);
        free_q[idx_q[AW-1:0]] <= 1'b0;
      end
      if (cmd_i.del_fix) begin
        count_q              <= count_q - CNT_W'(1);
        free_q[cur_q[AW-1:0]] <= 1'b1;
      end
      out_valid_q <= cmd_i.emit_item || cmd_i.emit_reply || (out_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_e'(operation_i);
      pos_q <= position_i;
      val_q <= value_i;
    end
    cur_q <= cur_d;
    if (cmd_i.seek) begin
      steps_q <= seek_len;
    end else if (cmd_i.step) begin
      steps_q <= steps_q - CNT_W'(1);
    end
    if (cmd_i.latch) begin
      idx_q <= free_idx;
      if (is_ins && (p == PW'(1))) begin
        before_q <= NULL_IDX;
        after_q  <= head_q;
      end else if (is_ins) begin
        before_q <= cur_q;
        after_q  <= next_rdata;
      end else begin
        before_q <= prev_rdata;
        after_q  <= next_rdata;
      end
    end
    if (cmd_i.set_st) begin
      status_q <= cmd_i.st;
    end
    if (cmd_i.emit_item) begin
      out_status_q <= ST_DONE;
      out_value_q  <= val_rdata;
      out_held_q   <= HELD_W'(count_q);
      out_last_q   <= (steps_q == '0);
    end else if (cmd_i.emit_reply) begin
      out_status_q <= status_q;
      out_value_q  <= '0;
      out_held_q   <= HELD_W'(count_q);
      out_last_q   <= 1'b1;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign item_value_o   = $signed(out_value_q);
  assign entries_held_o = out_held_q;
  assign last_result_o  = out_last_q;

  a_pool_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(free_q) + int'(count_q) == POOL_DEPTH)
    else $error("free map and entry count disagree");

  a_head_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) == (head_q == NULL_IDX))
    else $error("head index inconsistent with entry count");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_item || cmd_i.emit_reply) |-> slot_free)
    else $error("result register overwritten before taken");

  a_alloc_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ins_link |-> free_q[idx_q[AW-1:0]])
    else $error("insert writes a node that is in use");

  a_one_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.emit_item && cmd_i.emit_reply))
    else $error("two results issued in one cycle");

endmodule

/* rtl/core/positional_list_engine.sv */
// Doubly linked list of signed 32-bit values in a pool of POOL_DEPTH nodes.
// One item is taken at a time; in_ready_o is high only while the engine is
// idle, but a result may still be waiting in the output register. Node
// values and both link arrays sit in registered-read RAMs, and every walk
// follows one forward link per cycle (a listing walk only while the output
// register is free); a listing sends one result per cycle while out_ready_i
// is high. New values go to the lowest-numbered free node. Listing returns
// at most the first 16 values, with last_result_o on the final one.
module positional_list_engine
  import ple_pkg::*;
#(
  parameter int POOL_DEPTH = DEF_POOL_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [OP_W-1:0]          operation_i,
  input  logic [POS_W-1:0]         position_i,
  input  logic signed [VAL_W-1:0]  value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [STATUS_W-1:0]      status_o,
  output logic signed [VAL_W-1:0]  item_value_o,
  output logic [HELD_W-1:0]        entries_held_o,
  output logic                     last_result_o
);

  cmd_t cmd;
  sts_t sts;

  ple_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ple_dp #(.POOL_DEPTH(POOL_DEPTH)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .operation_i    (operation_i),
    .position_i     (position_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .item_value_o   (item_value_o),
    .entries_held_o (entries_held_o),
    .last_result_o  (last_result_o)
  );

endmodule

/* tb/sv/tb_positional_list_engine.sv */
`timescale 1ns / 100ps

module tb_positional_list_engine;
  import ple_pkg::*;

  localparam int POOL_DEPTH   = DEF_POOL_DEPTH;
  localparam int RANDOM_ITEMS = 386;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int N_DIR        = 24;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;
  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_CHURN, MIX_NOISE} mix_e;

  typedef struct {
    status_e                  status;
    logic signed [VAL_W-1:0]  value;
    logic [HELD_W-1:0]        held;
    logic                     last;
  } reply_t;

  typedef struct packed {
    op_e                op;
    logic [POS_W-1:0]   pos;
    logic [VAL_W-1:0]   val;
    logic               typed;
    status_e            st;
    logic [HELD_W-1:0]  held;
  } dir_row_t;

  // typed rows carry their reply; the rest go through the list predictor
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{OP_LIST,      5'd3,  32'h0000_0000, 1'b1, ST_EMPTY, 5'd0},
    '{OP_DEL_FRONT, 5'd0,  32'h0000_0000, 1'b1, ST_EMPTY, 5'd0},
    '{OP_DEL_BACK,  5'd0,  32'h0000_0000, 1'b1, ST_EMPTY, 5'd0},
    '{OP_DEL_AT,    5'd1,  32'h0000_0000, 1'b1, ST_INVAL, 5'd0},
    '{OP_INS_AT,    5'd0,  32'h0000_0011, 1'b1, ST_INVAL, 5'd0},
    '{OP_INS_AT,    5'd2,  32'h0000_0022, 1'b1, ST_INVAL, 5'd0},
    '{OP_NOP,       5'd31, 32'hFFFF_FFFF, 1'b1, ST_DONE,  5'd0},
    '{OP_INS_FRONT, 5'd0,  32'h7FFF_FFFF, 1'b1, ST_DONE,  5'd1},
    '{OP_INS_BACK,  5'd0,  32'h8000_0000, 1'b1, ST_DONE,  5'd2},
    '{OP_INS_AT,    5'd1,  32'hFFFF_FFFF, 1'b1, ST_DONE,  5'd3},
    '{OP_INS_AT,    5'd4,  32'h0000_0000, 1'b1, ST_DONE,  5'd4},
    '{OP_INS_AT,    5'd31, 32'h0000_0005, 1'b1, ST_INVAL, 5'd4},
    '{OP_LIST,      5'd0,  32'h0000_0000, 1'b0, ST_DONE,  5'd0},
    '{OP_DEL_AT,    5'd0,  32'h0000_0000, 1'b1, ST_INVAL, 5'd4},
    '{OP_DEL_AT,    5'd5,  32'h0000_0000, 1'b1, ST_INVAL, 5'd4},
    '{OP_INS_AT,    5'd3,  32'h1234_5678, 1'b0, ST_DONE,  5'd0},
    '{OP_DEL_AT,    5'd2,  32'h0000_0000, 1'b1, ST_DONE,  5'd4},
    '{OP_DEL_FRONT, 5'd0,  32'h0000_0000, 1'b1, ST_DONE,  5'd3},
    '{OP_DEL_BACK,  5'd0,  32'h0000_0000, 1'b1, ST_DONE,  5'd2},
    '{OP_LIST,      5'd0,  32'h0000_0000, 1'b0, ST_DONE,  5'd0},
    '{OP_DEL_AT,    5'd16, 32'h0000_0000, 1'b1, ST_INVAL, 5'd2},
    '{OP_NOP,       5'd16, 32'hAAAA_AAAA, 1'b1, ST_DONE,  5'd2},
    '{OP_INS_AT,    5'd3,  32'h5555_5555, 1'b1, ST_DONE,  5'd3},
    '{OP_LIST,      5'd0,  32'h0000_0000, 1'b0, ST_DONE,  5'd0}
  };

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [OP_W-1:0]          operation_i = '0;
  logic [POS_W-1:0]         position_i = '0;
  logic signed [VAL_W-1:0]  value_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic [STATUS_W-1:0]      status_o;
  logic signed [VAL_W-1:0]  item_value_o;
  logic [HELD_W-1:0]        entries_held_o;
  logic                     last_result_o;

  logic signed [VAL_W-1:0]  shadow_list [$];
  reply_t                   reply_q [$];
  int unsigned              mismatch_cnt = 0;
  idle_mode_e               idle_mode = IDLE_NONE;
  bit                       rx_hold_req = 1'b0;

  positional_list_engine #(.POOL_DEPTH(POOL_DEPTH)) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .position_i     (position_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .item_value_o   (item_value_o),
    .entries_held_o (entries_held_o),
    .last_result_o  (last_result_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit roll_pause(input bit rx_side);
    int unsigned pct;
    case (idle_mode)
      IDLE_SENDER:   pct = rx_side ? 0 : 58;
      IDLE_RECEIVER: pct = rx_side ? 58 : 0;
      IDLE_BOTH:     pct = 6;
      default:       pct = 0;
    endcase
    return $urandom_range(99) < pct;
  endfunction

  task automatic push_reply(input status_e st, input logic signed [VAL_W-1:0] v,
                            input int unsigned held, input logic last);
    reply_t r;
    r.status = st;
    r.value  = v;
    r.held   = held[HELD_W-1:0];
    r.last   = last;
    reply_q.push_back(r);
  endtask

  // Applies one operation to the shadow list; queues its replies when record is set.
  task automatic predict_replies(input op_e op, input logic [POS_W-1:0] pos,
                                 input logic signed [VAL_W-1:0] val, input bit record);
    int unsigned held, slot, n;
    status_e     st;
    held = shadow_list.size();
    st   = ST_DONE;
    case (op)
      OP_LIST: begin
        if (held == 0) begin
          if (record) push_reply(ST_EMPTY, '0, 0, 1'b1);
        end else begin
          n = (held > MAX_RESULTS) ? MAX_RESULTS : held;
          for (int k = 0; k < n; k++)
            if (record) push_reply(ST_DONE, shadow_list[k], held, k == n - 1);
        end
      end
      OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
        slot = (op == OP_INS_FRONT) ? 1 : (op == OP_INS_BACK) ? held + 1 : pos;
        // position is checked ahead of the pool
        if (slot < 1 || slot > held + 1) st = ST_INVAL;
        else if (held >= POOL_DEPTH)     st = ST_FULL;
        else shadow_list.insert(slot - 1, val);
      end
      OP_DEL_FRONT, OP_DEL_BACK: begin
        if (held == 0) st = ST_EMPTY;
        else shadow_list.delete((op == OP_DEL_FRONT) ? 0 : held - 1);
      end
      OP_DEL_AT: begin
        if (pos < 1 || pos > held) st = ST_INVAL;
        else shadow_list.delete(pos - 1);
      end
      default: ;
    endcase
    if (op != OP_LIST && record) push_reply(st, '0, shadow_list.size(), 1'b1);
  endtask

  task automatic offer_item(input op_e op, input logic [POS_W-1:0] pos,
                            input logic signed [VAL_W-1:0] val,
                            input bit typed, input status_e st, input int unsigned held);
    while (roll_pause(1'b0)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    position_i  <= pos;
    value_i     <= val;
    do @(posedge clk_i); while (!in_ready_o);
    predict_replies(op, pos, val, !typed);
    if (typed) push_reply(st, '0, held, 1'b1);
  endtask

  task automatic roll_item(input mix_e mix, output op_e op, output logic [POS_W-1:0] pos,
                           output logic signed [VAL_W-1:0] val);
    int unsigned held, r, ins_pct;
    held = shadow_list.size();
    r    = $urandom_range(99);
    case (mix)
      MIX_GROW:   ins_pct = 72;
      MIX_SHRINK: ins_pct = 15;
      default:    ins_pct = 42;
    endcase
    if (mix == MIX_NOISE)       op = op_e'($urandom_range(7));
    else if (r < 10)            op = OP_LIST;
    else if (r < 10 + ins_pct)  op = op_e'($urandom_range(3, 1));
    else if (r < 97)            op = op_e'($urandom_range(6, 4));
    else                        op = OP_NOP;

    pos = POS_W'($urandom_range(31));
    if (op == OP_INS_AT && $urandom_range(99) < 80)
      pos = POS_W'($urandom_range(held + 1, 1));
    else if (op == OP_DEL_AT && held > 0 && $urandom_range(99) < 80)
      pos = POS_W'($urandom_range(held, 1));

    case ($urandom_range(15))
      0:       val = 32'sh7FFF_FFFF;
      1:       val = 32'sh8000_0000;
      2:       val = '0;
      3:       val = -1;
      default: val = $urandom;
    endcase
  endtask

  // receiver: random stalls per phase, plus one long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= !roll_pause(1'b1);
      end
    end
  end

  always @(posedge clk_i) begin
    reply_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (reply_q.size() == 0) begin
        $error("unexpected result: status %0d value %0d held %0d last %0b",
               status_o, item_value_o, entries_held_o, last_result_o);
        mismatch_cnt++;
      end else begin
        exp_r = reply_q.pop_front();
        if (status_o !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, status_o);
          mismatch_cnt++;
        end
        if (item_value_o !== exp_r.value) begin
          $error("item_value: expected %0d, got %0d", exp_r.value, item_value_o);
          mismatch_cnt++;
        end
        if (entries_held_o !== exp_r.held) begin
          $error("entries_held: expected %0d, got %0d", exp_r.held, entries_held_o);
          mismatch_cnt++;
        end
        if (last_result_o !== exp_r.last) begin
          $error("last_result: expected %0b, got %0b", exp_r.last, last_result_o);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("positional_list_engine regression: fail");
    $finish;
  end

  initial begin
    op_e                      op;
    logic [POS_W-1:0]         pos;
    logic signed [VAL_W-1:0]  val;
    mix_e                     mix;
    int unsigned              burst_left, r;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    idle_mode = IDLE_BOTH;
    foreach (DIR_ROWS[i])
      offer_item(DIR_ROWS[i].op, DIR_ROWS[i].pos, DIR_ROWS[i].val,
                 DIR_ROWS[i].typed, DIR_ROWS[i].st, DIR_ROWS[i].held);

    burst_left = 0;
    mix        = MIX_GROW;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      idle_mode = idle_mode_e'((n / 48) % 4);
      // long receiver hold while items keep coming: block fills and stalls
      if (n == 150) rx_hold_req = 1'b1;
      if (burst_left == 0) begin
        r = $urandom_range(99);
        mix = (r < 35) ? MIX_GROW : (r < 60) ? MIX_SHRINK : (r < 90) ? MIX_CHURN : MIX_NOISE;
        burst_left = $urandom_range(24, 8);
      end
      burst_left--;
      roll_item(mix, op, pos, val);
      offer_item(op, pos, val, 1'b0, ST_DONE, 0);
    end
    in_valid_i <= 1'b0;

    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0)
      $display("positional_list_engine regression: pass");
    else
      $display("positional_list_engine regression: fail");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/ple_pkg.sv
rtl/core/ple_ram.sv
rtl/core/ple_ctrl.sv
rtl/core/ple_dp.sv
rtl/core/positional_list_engine.sv
tb/sv/tb_positional_list_engine.sv
